[hdl/b64d_pkg.sv]
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, character constants and sextet lookup for the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CHAR_CARET = 8'h5E;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_LOW   = 8'd40;
  localparam logic [7:0] CHAR_HIGH  = 8'd130;
  localparam logic [5:0] SEXTET_MASK = 6'h3F;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;
  localparam logic [2:0] PAD_COUNT_MAX = 3'd7;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_LENGTH   = 2'd1,
    STATUS_BAD_CHAR     = 2'd2,
    STATUS_PAD_MISMATCH = 2'd3
  } status_t;

  // all results caused by one character
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n_bytes;
    logic            has_status;
    status_t         code;
    logic            marker;
  } burst_t;

  // {valid, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    begin
      r = '0;
      if (c < CHAR_LOW || c >= CHAR_HIGH) begin
        r = '0;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
        r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
        r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
        r = {1'b1, 6'd63};
      end
      return r;
    end
  endfunction

endpackage

[hdl/b64d_char_if.sv]
// ----------------------------------------------------------------------------
// b64d_char_if
// Character channel: one input character per transfer
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_message;

  modport source (output valid, output char_code, output end_of_message, input ready);
  modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

[hdl/b64d_result_if.sv]
// ----------------------------------------------------------------------------
// b64d_result_if
// Result channel: one decoded byte or one status item per transfer
// ----------------------------------------------------------------------------
interface b64d_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_status;
  logic [1:0] status_code;
  logic       compressed_marker;
  logic       last_of_run;

  modport source (output valid, output data_byte, output is_status, output status_code,
                  output compressed_marker, output last_of_run, input ready);
  modport sink   (input valid, input data_byte, input is_status, input status_code,
                  input compressed_marker, input last_of_run, output ready);
endinterface

[hdl/b64d_decoder.sv]
// ----------------------------------------------------------------------------
// b64d_decoder
// Message state and single-pass decode of one character into a result burst
// ----------------------------------------------------------------------------
module b64d_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      char_code,
  input  logic            end_of_message,
  output logic            push,
  output b64d_pkg::burst_t burst
);
  import b64d_pkg::*;

  logic [1:0]  quartet_phase;
  logic [17:0] held_sextets;
  logic        at_message_start;
  logic        saw_marker;
  logic        bad_char_seen;
  logic [2:0]  pad_chars_seen;
  logic [1:0]  recent_pad_flags;

  logic [1:0]  quartet_phase_next;
  logic [17:0] held_sextets_next;
  logic        saw_marker_next;
  logic        bad_char_seen_next;
  logic [2:0]  pad_chars_seen_next;
  logic [1:0]  recent_pad_flags_next;

  logic        is_marker;
  logic        is_pad;
  logic [6:0]  lookup;
  logic [5:0]  v;
  logic [1:0]  trailing;
  logic        final_char;
  logic [5:0]  x0, x1, x2;

  always_comb begin
    is_marker = at_message_start && (char_code == CHAR_CARET);
    is_pad    = !is_marker && (char_code == CHAR_PAD);
    lookup    = sextet_of(char_code);
    v         = (is_pad || !lookup[6]) ? 6'd0 : (lookup[5:0] & SEXTET_MASK);
    final_char = !is_marker && (quartet_phase == 2'd3);

    bad_char_seen_next  = bad_char_seen | (!is_marker && !is_pad && !lookup[6]);
    pad_chars_seen_next = (is_pad && pad_chars_seen != PAD_COUNT_MAX) ?
                          pad_chars_seen + 3'd1 : pad_chars_seen;
    trailing = (is_pad && end_of_message) ? 2'd1 + {1'b0, recent_pad_flags[0]} : 2'd0;
    recent_pad_flags_next = is_marker ? recent_pad_flags : {recent_pad_flags[0], is_pad};
    saw_marker_next = saw_marker | is_marker;

    if (is_marker) begin
      quartet_phase_next = quartet_phase;
      held_sextets_next  = held_sextets;
    end else if (final_char) begin
      quartet_phase_next = 2'd0;
      held_sextets_next  = '0;
    end else begin
      quartet_phase_next = quartet_phase + 2'd1;
      held_sextets_next  = {held_sextets[11:0], v};
    end

    x0 = held_sextets[17:12];
    x1 = held_sextets[11:6];
    x2 = held_sextets[5:0];
    burst.bytes[0] = {x0, x1[5:4]};
    burst.bytes[1] = {x1[3:0] & NIBBLE_MASK, x2[5:2]};
    burst.bytes[2] = {x2[1:0], v};
    burst.n_bytes  = final_char ? (end_of_message ? 2'd3 - trailing : 2'd3) : 2'd0;
    burst.has_status = end_of_message;
    burst.marker     = saw_marker_next;

    priority if (quartet_phase_next != 2'd0) begin
      burst.code = STATUS_BAD_LENGTH;
    end else if (bad_char_seen_next) begin
      burst.code = STATUS_BAD_CHAR;
    end else if (pad_chars_seen_next != {1'b0, trailing}) begin
      burst.code = STATUS_PAD_MISMATCH;
    end else begin
      burst.code = STATUS_OK;
    end

    push = accept && (end_of_message || final_char);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_message)) begin
      quartet_phase    <= '0;
      held_sextets     <= '0;
      at_message_start <= 1'b1;
      saw_marker       <= 1'b0;
      bad_char_seen    <= 1'b0;
      pad_chars_seen   <= '0;
      recent_pad_flags <= '0;
    end else if (accept) begin
      quartet_phase    <= quartet_phase_next;
      held_sextets     <= held_sextets_next;
      at_message_start <= 1'b0;
      saw_marker       <= saw_marker_next;
      bad_char_seen    <= bad_char_seen_next;
      pad_chars_seen   <= pad_chars_seen_next;
      recent_pad_flags <= recent_pad_flags_next;
    end
  end

endmodule

[hdl/b64d_burst_queue.sv]
// ----------------------------------------------------------------------------
// b64d_burst_queue
// Two-entry burst buffer that hands out one result item per transfer
// ----------------------------------------------------------------------------
module b64d_burst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::burst_t burst,
  output logic             room,
  b64d_result_if.source    results
);
  import b64d_pkg::*;

  burst_t      entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  idx;
  burst_t      head;
  logic [2:0]  total;
  logic        last;
  logic        is_data;
  logic        xfer;
  logic        pop;

  always_comb begin
    head    = entry[rd_ptr];
    total   = {1'b0, head.n_bytes} + {2'b00, head.has_status};
    last    = ({1'b0, idx} == total - 3'd1);
    is_data = idx < head.n_bytes;
    room    = count != 2'd2;

    results.valid = count != 2'd0;
    unique case (idx)
      2'd0:    results.data_byte = is_data ? head.bytes[0] : 8'h00;
      2'd1:    results.data_byte = is_data ? head.bytes[1] : 8'h00;
      2'd2:    results.data_byte = is_data ? head.bytes[2] : 8'h00;
      default: results.data_byte = 8'h00;
    endcase
    results.is_status         = !is_data;
    results.status_code       = is_data ? STATUS_OK : head.code;
    results.compressed_marker = head.marker;
    results.last_of_run       = last;

    xfer = results.valid && results.ready;
    pop  = xfer && last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      idx    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        idx    <= '0;
      end else if (xfer) begin
        idx <= idx + 2'd1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/base64_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 message decoder, one character per cycle in, bytes and status out
//
// chars carries one character per transfer with end_of_message on the last
// character of a message. results carries decoded bytes and, after the last
// character, one status item (is_status high) with the message status and
// the compressed flag; last_of_run marks the final item caused by a character.
// Every character is decoded in the cycle it is taken; its results, up to
// four items, sit in a two-entry burst buffer and leave one per cycle while
// results is ready. Characters are taken every cycle while the buffer has
// space; only the fourth character of a quartet and the last character of a
// message fill an entry, so sustained input is one character per cycle,
// limited by the result channel draining one item per cycle. When results
// stalls the buffer fills and chars.ready drops. Reset clears the message
// state and empties the buffer; a message also returns to the reset state
// after its status item is produced.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
  input  logic          clk,
  input  logic          rst,
  b64d_char_if.sink     chars,
  b64d_result_if.source results
);
  import b64d_pkg::*;

  logic   accept;
  logic   push;
  logic   room;
  burst_t burst;

  assign chars.ready = room;
  assign accept      = chars.valid && chars.ready;

  b64d_decoder u_decoder (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .char_code      (chars.char_code),
    .end_of_message (chars.end_of_message),
    .push           (push),
    .burst          (burst)
  );

  b64d_burst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .burst   (burst),
    .room    (room),
    .results (results)
  );

  // bursts only come from accepted characters
  assert property (@(posedge clk) disable iff (rst) push |-> accept)
    else $error("burst written without a character transfer");

  // end of message always yields a status
  assert property (@(posedge clk) disable iff (rst)
    accept && chars.end_of_message |-> push && burst.has_status)
    else $error("end of message without status burst");

  // status item closes its run
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.is_status |-> results.last_of_run)
    else $error("status item not last of run");

  // data items carry no status code
  assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.is_status |-> results.status_code == STATUS_OK)
    else $error("data item with status code");

endmodule

[tb/base64_stream_decoder_top_tb.sv]
// ----------------------------------------------------------------------------
// base64_stream_decoder_top_tb
// Self-checking bench for the base64 stream decoder
//
// A short directed set of messages covers padding, the compression marker,
// invalid characters, stray padding and short messages. Random messages
// follow: mostly well formed with random content, some corrupted by a stray
// byte, a dropped character, an inner '=' or a late '^'. Each accepted
// character is run through a decoder model in the bench and every result
// transfer is checked in order against the predicted bytes and status.
// Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top_tb;
  import b64d_pkg::*;

  localparam int unsigned MODE_NONE       = 0;
  localparam int unsigned MODE_SEND_IDLE  = 1;
  localparam int unsigned MODE_RECV_STALL = 2;
  localparam int unsigned MODE_BOTH       = 3;
  localparam int unsigned RANDOM_ITEMS    = 170;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  typedef struct {
    logic [7:0]  char_code;
    logic        end_of_message;
    bit          wait_drained;
    int unsigned idle_mode;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    status_t    status_code;
    logic       compressed_marker;
    logic       last_of_run;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b64d_char_if   chars ();
  b64d_result_if results ();

  base64_stream_decoder_top DUT (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always #2 clk = ~clk;

  char_item_t  pending_chars[$];
  decoded_t    expected_results[$];
  int unsigned idle_mode = MODE_NONE;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gen_mode = MODE_NONE;
  bit          gen_drain = 1'b0;

  // decoder model state
  logic [1:0]  q_phase;
  logic [17:0] q_sextets;
  logic        msg_start;
  logic        msg_marker;
  logic        msg_bad_char;
  logic [2:0]  msg_pad_count;
  logic [1:0]  msg_pad_hist;

  function automatic void clear_message_state();
    q_phase       = '0;
    q_sextets     = '0;
    msg_start     = 1'b1;
    msg_marker    = 1'b0;
    msg_bad_char  = 1'b0;
    msg_pad_count = '0;
    msg_pad_hist  = '0;
  endfunction

  // {valid, value}
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= CHAR_LOW && c < CHAR_HIGH) begin
      if (c >= "A" && c <= "Z") begin
        r = {1'b1, 6'(c - "A")};
      end else if (c >= "a" && c <= "z") begin
        r = {1'b1, 6'(c - "a" + 8'd26)};
      end else if (c >= "0" && c <= "9") begin
        r = {1'b1, 6'(c - "0" + 8'd52)};
      end else if (c == "+") begin
        r = {1'b1, 6'd62};
      end else if (c == "/") begin
        r = {1'b1, 6'd63};
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] sextet_to_char(input int unsigned v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eom);
    decoded_t   run[$];
    decoded_t   r;
    logic [6:0] sx;
    logic [5:0] val;
    logic [7:0] bytes[3];
    logic [1:0] trailing;
    int         count;
    bit         pad;
    status_t    code;
    trailing = '0;
    val = '0;
    if (msg_start && c == CHAR_CARET) begin
      msg_start = 1'b0;
      msg_marker = 1'b1;
    end else begin
      msg_start = 1'b0;
      pad = (c == CHAR_PAD);
      if (pad) begin
        if (msg_pad_count != PAD_COUNT_MAX) msg_pad_count++;
        trailing = 2'd1 + msg_pad_hist[0];
      end else begin
        sx = char_to_sextet(c);
        if (sx[6]) val = sx[5:0];
        else msg_bad_char = 1'b1;
      end
      msg_pad_hist = {msg_pad_hist[0], pad};
      if (q_phase == 2'd3) begin
        bytes[0] = {q_sextets[17:12], q_sextets[11:10]};
        bytes[1] = {q_sextets[9:6], q_sextets[5:2]};
        bytes[2] = {q_sextets[1:0], val};
        count = eom ? 3 - trailing : 3;
        for (int i = 0; i < count; i++) begin
          r = '0;
          r.data_byte = bytes[i];
          r.compressed_marker = msg_marker;
          run.push_back(r);
        end
        q_phase = '0;
        q_sextets = '0;
      end else begin
        q_sextets = {q_sextets[11:0], val};
        q_phase++;
      end
    end
    if (eom) begin
      if (q_phase != 2'd0) code = STATUS_BAD_LENGTH;
      else if (msg_bad_char) code = STATUS_BAD_CHAR;
      else if (msg_pad_count != {1'b0, trailing}) code = STATUS_PAD_MISMATCH;
      else code = STATUS_OK;
      r = '0;
      r.is_status = 1'b1;
      r.status_code = code;
      r.compressed_marker = msg_marker;
      run.push_back(r);
      clear_message_state();
    end
    if (run.size() > 0) run[$].last_of_run = 1'b1;
    foreach (run[i]) expected_results.push_back(run[i]);
  endfunction

  task automatic push_message(input logic [7:0] msg[$]);
    foreach (msg[i]) begin
      pending_chars.push_back('{msg[i], logic'(i == msg.size() - 1), gen_drain, gen_mode});
      gen_drain = 1'b0;
    end
  endtask

  task automatic push_text(input string s);
    logic [7:0] msg[$];
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    push_message(msg);
  endtask

  // character transfers
  always @(posedge clk) begin : drive_chars
    bit go;
    if (rst) begin
      chars.valid <= 1'b0;
    end else begin
      if (chars.valid && chars.ready) begin
        decode_char(chars.char_code, chars.end_of_message);
        void'(pending_chars.pop_front());
      end
      if (!chars.valid || chars.ready) begin
        go = pending_chars.size() > 0;
        if (go && pending_chars[0].wait_drained && expected_results.size() > 0) go = 1'b0;
        if (go && pending_chars[0].idle_mode == MODE_SEND_IDLE && $urandom_range(0, 99) < 54)
          go = 1'b0;
        if (go && pending_chars[0].idle_mode == MODE_BOTH && $urandom_range(0, 99) < 24)
          go = 1'b0;
        if (go) begin
          chars.valid <= 1'b1;
          chars.char_code <= pending_chars[0].char_code;
          chars.end_of_message <= pending_chars[0].end_of_message;
          idle_mode <= pending_chars[0].idle_mode;
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // result transfers and watchdog
  always @(posedge clk) begin : check_results
    decoded_t got;
    decoded_t want;
    bit       stall;
    if (rst) begin
      results.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (results.valid && results.ready) begin
        got = '0;
        got.data_byte = results.data_byte;
        got.is_status = results.is_status;
        got.status_code = status_t'(results.status_code);
        got.compressed_marker = results.compressed_marker;
        got.last_of_run = results.last_of_run;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      stall = (idle_mode == MODE_RECV_STALL && $urandom_range(0, 99) < 54) ||
              (idle_mode == MODE_BOTH && $urandom_range(0, 99) < 24);
      results.ready <= !stall;
      if ((chars.valid && chars.ready) || (results.valid && results.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0]  msg[$];
    int unsigned msg_no;
    int unsigned n_quartets;
    int unsigned n_pads;
    int unsigned pos;
    chars.valid = 1'b0;
    chars.char_code = '0;
    chars.end_of_message = 1'b0;
    results.ready = 1'b0;
    clear_message_state();

    // directed messages
    push_text("TWFu");
    push_text("^");
    push_text("^QQ==");
    push_text("//8=");
    push_text("A=AA");
    msg = '{8'h00, 8'hFF, "z", "9"};
    push_message(msg);
    push_text("Q^");

    // random messages
    msg_no = 0;
    while (pending_chars.size() < 24 + RANDOM_ITEMS) begin
      gen_mode = (msg_no / 4) % 4;
      gen_drain = (msg_no % 7 == 0);
      msg.delete();
      if ($urandom_range(0, 3) == 0) msg.push_back(CHAR_CARET);
      n_quartets = $urandom_range(0, 2);
      if (n_quartets == 0 && msg.size() == 0) n_quartets = 1;
      for (int i = 0; i < 4 * n_quartets; i++) msg.push_back(sextet_to_char($urandom_range(0, 63)));
      if (n_quartets > 0) begin
        n_pads = $urandom_range(0, 2);
        for (int i = 0; i < n_pads; i++) msg[msg.size() - 1 - i] = CHAR_PAD;
      end
      if ($urandom_range(0, 9) >= 8) begin
        pos = $urandom_range(0, msg.size() - 1);
        case ($urandom_range(0, 3))
          0: msg[pos] = 8'($urandom_range(0, 255));
          1: if (msg.size() > 1) msg.delete(pos);
          2: msg.insert(pos, CHAR_PAD);
          default: msg.insert(pos, CHAR_CARET);
        endcase
      end
      push_message(msg);
      msg_no++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || chars.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/b64d_pkg.sv
hdl/b64d_char_if.sv
hdl/b64d_result_if.sv
hdl/b64d_decoder.sv
hdl/b64d_burst_queue.sv
hdl/base64_stream_decoder_top.sv
tb/base64_stream_decoder_top_tb.sv
